// File: hdl/nfs_pkg.sv
package nfs_pkg;

    localparam int MAX_TAPS  = 7;
    localparam int SAMPLE_W  = 32;
    localparam int TAP_W     = 16;
    localparam int CNT_W     = 3;
    localparam int TAP_IDX_W = $clog2(MAX_TAPS);
    localparam int PROD_W    = SAMPLE_W + TAP_W;
    localparam int ACC_W     = PROD_W + $clog2(MAX_TAPS);
    localparam int WSUM_W    = TAP_W + $clog2(MAX_TAPS);
    localparam int QUO_W     = SAMPLE_W + 1;
    localparam int QCNT_W    = $clog2(QUO_W + 1);
    localparam int CFG_IDX_W = 4;

    localparam logic [CNT_W-1:0] RCV_MAX = CNT_W'(7);

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_BASE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_END   = CFG_IDX_W'(MAX_TAPS + 1);

    localparam logic [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage

// File: hdl/nfs_div.sv
module nfs_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [nfs_pkg::ACC_W-1:0]  i_dividend,
    input  logic signed [nfs_pkg::WSUM_W-1:0] i_divisor,
    output logic                              o_done,
    output logic [nfs_pkg::SAMPLE_W-1:0]      o_quotient
);
    import nfs_pkg::*;

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;

    logic [1:0]          r_state;
    logic [QCNT_W-1:0]   r_cnt;
    logic [WSUM_W-1:0]   r_rem;
    logic [QUO_W-1:0]    r_quo;
    logic [WSUM_W-1:0]   r_dmag;
    logic                r_neg;
    logic                r_sat;
    logic                r_done;
    logic [SAMPLE_W-1:0] r_res;

    logic [ACC_W-1:0]       dvd_mag;
    logic [WSUM_W-1:0]      dvs_mag;
    logic [WSUM_W-1:0]      hi_ext;
    logic [WSUM_W:0]        trial;
    logic [WSUM_W:0]        diff;
    logic                   ge;
    logic                   pos_ovf;
    logic                   neg_ovf;
    logic [SAMPLE_W-1:0]    fin_res;

    always_comb begin
        dvd_mag = i_dividend[ACC_W-1] ? ACC_W'(-i_dividend) : ACC_W'(i_dividend);
        dvs_mag = i_divisor[WSUM_W-1] ? WSUM_W'(-i_divisor) : WSUM_W'(i_divisor);
        hi_ext  = {{(WSUM_W-ACC_W+QUO_W){1'b0}}, dvd_mag[ACC_W-1:QUO_W]};
        trial   = {r_rem, r_quo[QUO_W-1]};
        diff    = trial - {1'b0, r_dmag};
        ge      = trial >= {1'b0, r_dmag};
        pos_ovf = |r_quo[QUO_W-1:SAMPLE_W-1];
        neg_ovf = (|r_quo[QUO_W-1:SAMPLE_W])
                  || (r_quo[SAMPLE_W-1] && (|r_quo[SAMPLE_W-2:0]));
        if (r_neg) begin
            fin_res = (r_sat || neg_ovf) ? SAT_MIN : -r_quo[SAMPLE_W-1:0];
        end else begin
            fin_res = (r_sat || pos_ovf) ? SAT_MAX : r_quo[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_dmag <= dvs_mag;
                        r_neg  <= i_dividend[ACC_W-1] ^ i_divisor[WSUM_W-1];
                        r_rem  <= hi_ext;
                        r_quo  <= dvd_mag[QUO_W-1:0];
                        r_cnt  <= QCNT_W'(QUO_W);
                        // quotient too wide for the low bits alone
                        r_sat  <= hi_ext >= dvs_mag;
                        r_state <= (hi_ext >= dvs_mag) ? D_FIN : D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= ge ? diff[WSUM_W-1:0] : trial[WSUM_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], ge};
                    r_cnt <= r_cnt - QCNT_W'(1);
                    if (r_cnt == QCNT_W'(1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    r_res   <= fin_res;
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_res;

endmodule

// File: hdl/normalized_fir_smoother.sv
// channel   | dir | handshake            | payload
// s stream  | in  | i_s_tvalid/o_s_tready | tdata: sample_in[31:0]; tlast: last_in
// m stream  | out | o_m_tvalid/i_m_tready | tdata: smoothed[31:0]; tlast: last_out;
//           |     |                       | tuser: weight_error
// cfg write | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data[15:0]
//
// one word is taken only while the sequencer is idle; it gives 0 to 4 results
// a word with no result passes a check and an advance; each result adds a check, len steps on
// the shared 32x16 multiplier (one tap per cycle), closing the sum, the shift-subtract divider
// (33 steps, skipped when the high bits already overflow), loading the output and an advance;
// a zero weight sum skips the divider; a result held by a low i_m_tready stalls the next one
// in the output state
// reset (synchronous, active low) restores tap_count 1, tap_0 1, other taps 0
// the cfg channel is always ready
module normalized_fir_smoother (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [nfs_pkg::SAMPLE_W-1:0]     i_s_tdata,   // sample_in
    input  logic                             i_s_tlast,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [nfs_pkg::SAMPLE_W-1:0]     o_m_tdata,   // smoothed
    output logic                             o_m_tlast,
    output logic                             o_m_tuser,   // weight_error
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nfs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nfs_pkg::TAP_W-1:0]        i_cfg_data
);
    import nfs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_DIVST = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] S_ADV   = 3'd7;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic [CNT_W-1:0]           r_rcv;
    logic                       r_last;
    logic signed [SAMPLE_W-1:0] r_x;
    logic [CNT_W-1:0]           r_len;
    logic [CNT_W-1:0]           r_ahead;
    logic [CNT_W-1:0]           r_rep;
    logic [TAP_IDX_W-1:0]       r_j;
    logic signed [SAMPLE_W-1:0] r_win [MAX_TAPS];
    logic signed [TAP_W-1:0]    r_tap [MAX_TAPS];
    logic [CNT_W-1:0]           r_count;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_pv;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [WSUM_W-1:0]   r_wsum;
    logic [SAMPLE_W-1:0]        r_res;
    logic                       r_err;
    logic                       r_ov;
    logic [SAMPLE_W-1:0]        r_od;
    logic                       r_olast;
    logic                       r_oerr;

    logic                       s_acc;
    logic [CNT_W-1:0]           len_eff;
    logic [TAP_IDX_W-1:0]       win_idx;
    logic signed [PROD_W-1:0]   prod;
    logic                       emit;
    logic                       more;
    logic                       out_free;
    logic                       div_start;
    logic                       div_done;
    logic [SAMPLE_W-1:0]        div_q;
    logic [TAP_IDX_W-1:0]       tap_wr_idx;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_ov;
    assign o_m_tdata   = r_od;
    assign o_m_tlast   = r_olast;
    assign o_m_tuser   = r_oerr;

    always_comb begin
        if (r_count == '0) begin
            len_eff = CNT_W'(1);
        end else if (r_count > CNT_W'(MAX_TAPS)) begin
            len_eff = CNT_W'(MAX_TAPS);
        end else begin
            len_eff = r_count;
        end
        win_idx    = TAP_IDX_W'(MAX_TAPS) - TAP_IDX_W'(r_len) + r_j;
        prod       = r_win[win_idx] * r_tap[r_j];
        emit       = ({1'b0, r_rcv} + {1'b0, r_rep}) > {1'b0, r_ahead};
        more       = r_last && (r_rep < r_ahead);
        out_free   = !r_ov || i_m_tready;
        div_start  = (r_state == S_DIVST) && (r_wsum != '0);
        tap_wr_idx = TAP_IDX_W'(i_cfg_index - CFG_TAP_BASE);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_acc) n_state = S_CHECK;
            S_CHECK: n_state = emit ? S_MAC : S_ADV;
            S_MAC:   if (r_j == TAP_IDX_W'(r_len - CNT_W'(1))) n_state = S_FIN;
            S_FIN:   n_state = S_DIVST;
            S_DIVST: n_state = (r_wsum == '0) ? S_OUT : S_DIV;
            S_DIV:   if (div_done) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_ADV;
            S_ADV:   n_state = more ? S_CHECK : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // tap registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(1);
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_tap[i] <= (i == 0) ? TAP_W'(1) : '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TAP_COUNT) begin
                r_count <= i_cfg_data[CNT_W-1:0];
            end else if (i_cfg_index >= CFG_TAP_BASE && i_cfg_index < CFG_TAP_END) begin
                r_tap[tap_wr_idx] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rcv   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_x     <= i_s_tdata;
                        r_last  <= i_s_tlast;
                        r_len   <= len_eff;
                        r_ahead <= len_eff >> 1;
                        r_rep   <= '0;
                        r_rcv   <= (r_rcv == RCV_MAX) ? r_rcv : r_rcv + CNT_W'(1);
                        for (int i = 0; i < MAX_TAPS - 1; i++) begin
                            r_win[i] <= (r_rcv == '0) ? i_s_tdata : r_win[i+1];
                        end
                        r_win[MAX_TAPS-1] <= i_s_tdata;
                    end
                end
                S_CHECK: begin
                    r_j    <= '0;
                    r_pv   <= 1'b0;
                    r_acc  <= '0;
                    r_wsum <= '0;
                end
                S_MAC: begin
                    r_prod <= prod;
                    r_pv   <= 1'b1;
                    if (r_pv) begin
                        r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                    end
                    r_wsum <= r_wsum + {{(WSUM_W-TAP_W){r_tap[r_j][TAP_W-1]}}, r_tap[r_j]};
                    r_j    <= r_j + TAP_IDX_W'(1);
                end
                S_FIN: begin
                    r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                end
                S_DIVST: begin
                    if (r_wsum == '0) begin
                        r_res <= '0;
                        r_err <= 1'b1;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res <= div_q;
                        r_err <= 1'b0;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_od    <= r_res;
                        r_err   <= r_err;
                        r_oerr  <= r_err;
                        r_olast <= r_last && (r_rep == r_ahead);
                    end
                end
                S_ADV: begin
                    if (more) begin
                        r_rep <= r_rep + CNT_W'(1);
                        for (int i = 0; i < MAX_TAPS - 1; i++) begin
                            r_win[i] <= r_win[i+1];
                        end
                        r_win[MAX_TAPS-1] <= r_x;
                    end else if (r_last) begin
                        r_rcv <= '0;
                    end
                end
                default: begin
                    r_rep <= r_rep;
                end
            endcase
        end
    end

    nfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_wsum),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == S_CHECK))
        else $error("accepted word did not start a window check");

    a_flush_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_rep <= r_ahead))
        else $error("flush count ran past the look-ahead");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("weight error word carries non-zero data");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

endmodule

// File: tb/normalized_fir_smoother_test.sv
`timescale 1ns / 1ps

module normalized_fir_smoother_test;

    import nfs_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 24;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_TOP = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smoothed;
        logic                last_out;
        logic                weight_error;
    } t_smoothed_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [SAMPLE_W-1:0]  i_s_tdata = '0;
    logic                 i_s_tlast = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [SAMPLE_W-1:0]  o_m_tdata;
    logic                 o_m_tlast;
    logic                 o_m_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TAP_W-1:0]     i_cfg_data = '0;

    // filter state as the block should hold it
    logic signed [SAMPLE_W-1:0] hist [MAX_TAPS];
    logic [CNT_W-1:0]           seen_count;
    logic [CNT_W-1:0]           taps_in_use;
    logic signed [TAP_W-1:0]    weights [MAX_TAPS];

    t_smoothed_word   pending_words [$];
    logic [TAP_W-1:0] tap_plan [MAX_TAPS];

    int samples_sent    = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int mismatch_count  = 0;
    int rx_hold_cycles  = 0;
    bit tx_calm         = 1'b0;
    bit rx_calm         = 1'b0;

    normalized_fir_smoother u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // sample_in
        .i_s_tlast   (i_s_tlast),   // last_in
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // smoothed
        .o_m_tlast   (o_m_tlast),   // last_out
        .o_m_tuser   (o_m_tuser),   // weight_error
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            i_m_tready <= 1'b0;
        end else if (rx_calm) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= 17);
        end
    end

    always @(posedge i_clk) begin
        t_smoothed_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_checked++;
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected word: smoothed %0d last %b error %b",
                             $signed(o_m_tdata), o_m_tlast, o_m_tuser);
            end else begin
                want = pending_words.pop_front();
                if (o_m_tdata !== want.smoothed || o_m_tlast !== want.last_out ||
                    o_m_tuser !== want.weight_error) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("word %0d: expected %0d/%b/%b, got %0d/%b/%b",
                                 results_checked, $signed(want.smoothed), want.last_out,
                                 want.weight_error, $signed(o_m_tdata), o_m_tlast,
                                 o_m_tuser);
                end
            end
        end
    end

    function automatic void reset_filter_state();
        int i;
        for (i = 0; i < MAX_TAPS; i++) begin
            hist[i]    = '0;
            weights[i] = '0;
        end
        weights[0]  = TAP_W'(1);
        taps_in_use = CNT_W'(1);
        seen_count  = '0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [TAP_W-1:0] data);
        if (idx == CFG_TAP_COUNT)
            taps_in_use = data[CNT_W-1:0];
        else if (idx >= CFG_TAP_BASE && idx < CFG_TAP_END)
            weights[idx - CFG_TAP_BASE] = data;
    endfunction

    function automatic void shift_in_sample(logic [SAMPLE_W-1:0] sample);
        int i;
        for (i = 0; i < MAX_TAPS - 1; i++)
            hist[i] = hist[i + 1];
        hist[MAX_TAPS - 1] = sample;
    endfunction

    function automatic t_smoothed_word weighted_average(int unsigned len);
        t_smoothed_word word;
        longint acc;
        longint wsum;
        longint quo;
        int unsigned j;
        acc  = 0;
        wsum = 0;
        for (j = 0; j < len; j++) begin
            acc  += longint'(hist[MAX_TAPS - len + j]) * longint'(weights[j]);
            wsum += longint'(weights[j]);
        end
        word.last_out = 1'b0;
        if (wsum == 0) begin
            word.smoothed     = '0;
            word.weight_error = 1'b1;
        end else begin
            quo = acc / wsum;
            if (quo > longint'($signed(SAT_MAX)))
                quo = longint'($signed(SAT_MAX));
            if (quo < longint'($signed(SAT_MIN)))
                quo = longint'($signed(SAT_MIN));
            word.smoothed     = SAMPLE_W'(quo);
            word.weight_error = 1'b0;
        end
        return word;
    endfunction

    function automatic void predict_smoothing(logic [SAMPLE_W-1:0] sample, logic last_in);
        int unsigned len;
        int unsigned off;
        int unsigned ahead;
        int unsigned cnt;
        int unsigned r;
        int unsigned made;
        int i;
        t_smoothed_word tail;
        len = (taps_in_use == 0) ? 1 : taps_in_use;
        if (len > MAX_TAPS)
            len = MAX_TAPS;
        off   = (len % 2 == 0) ? len / 2 - 1 : (len - 1) / 2;
        ahead = len - 1 - off;
        if (seen_count == 0)
            for (i = 0; i < MAX_TAPS; i++)
                hist[i] = sample;
        shift_in_sample(sample);
        cnt = seen_count + 1;
        if (cnt > RCV_MAX)
            cnt = RCV_MAX;
        seen_count = CNT_W'(cnt);
        made = 0;
        if (cnt > ahead) begin
            pending_words.push_back(weighted_average(len));
            made++;
        end
        if (last_in) begin
            for (r = 1; r <= ahead; r++) begin
                shift_in_sample(sample);
                if (cnt + r > ahead) begin
                    pending_words.push_back(weighted_average(len));
                    made++;
                end
            end
            if (made > 0) begin
                tail = pending_words.pop_back();
                tail.last_out = 1'b1;
                pending_words.push_back(tail);
            end
            seen_count = '0;
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom();
        if (roll < 85)
            return SAMPLE_W'($urandom_range(32'h0003_FFFF) - 32'h0002_0000);
        case ($urandom_range(3))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic void clear_plan();
        int i;
        for (i = 0; i < MAX_TAPS; i++)
            tap_plan[i] = '0;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TAP_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        apply_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic load_taps(logic [TAP_W-1:0] count_word);
        int i;
        write_reg(CFG_TAP_COUNT, count_word);
        for (i = 0; i < MAX_TAPS; i++)
            write_reg(CFG_IDX_W'(CFG_TAP_BASE + i), tap_plan[i]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(logic [SAMPLE_W-1:0] sample, logic last_in);
        if (!tx_calm && $urandom_range(99) < 17) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 17)
                @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= sample;
        i_s_tlast  <= last_in;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        predict_smoothing(sample, last_in);
        samples_sent++;
    endtask

    task automatic send_run(int n, bit closed);
        int k;
        for (k = 0; k < n; k++)
            send_sample(pick_sample(), closed && k == n - 1);
    endtask

    task automatic wait_for_drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_sample(SAT_MAX, 1'b0);
        send_sample(SAT_MIN, 1'b1);
        send_sample('1, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_saturation();
        clear_plan();
        tap_plan[0] = TAP_W'(2);
        tap_plan[1] = TAP_W'(-1);
        load_taps(TAP_W'(2));
        send_sample(SAT_MAX, 1'b0);
        send_sample(SAT_MIN, 1'b0);
        send_sample(SAT_MIN, 1'b0);
        send_sample(SAT_MAX, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_zero_weight_sum();
        clear_plan();
        tap_plan[0] = TAP_W'(1);
        tap_plan[1] = TAP_W'(-2);
        tap_plan[2] = TAP_W'(1);
        load_taps(TAP_W'(3));
        send_sample(32'h0001_8000, 1'b0);
        send_sample(32'hFFFE_0000, 1'b0);
        send_sample(32'h0000_0001, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_short_full_window();
        tap_plan[0] = TAP_W'(32767);
        tap_plan[1] = TAP_W'(-32768);
        tap_plan[2] = TAP_W'(5);
        tap_plan[3] = TAP_W'(-3);
        tap_plan[4] = TAP_W'(100);
        tap_plan[5] = TAP_W'(-1);
        tap_plan[6] = TAP_W'(7);
        // upper data bits set, tap count field reads as seven
        load_taps(16'hFFFF);
        send_sample(32'h7FFF_0000, 1'b0);
        send_sample(32'h8001_0000, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_zero_tap_count();
        write_reg(CFG_TAP_COUNT, 16'hFFF8);
        i_cfg_valid <= 1'b0;
        send_sample(32'h1234_5678, 1'b0);
        send_sample(32'hEDCB_A988, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_mid_sequence_change();
        clear_plan();
        tap_plan[0] = TAP_W'(1);
        tap_plan[1] = TAP_W'(2);
        tap_plan[2] = TAP_W'(3);
        tap_plan[3] = TAP_W'(2);
        tap_plan[4] = TAP_W'(1);
        load_taps(TAP_W'(5));
        send_run(3, 1'b0);
        wait_for_drain();
        tap_plan[0] = TAP_W'(-1);
        tap_plan[5] = TAP_W'(4);
        load_taps(TAP_W'(6));
        send_run(3, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_unmapped_index();
        write_reg(CFG_TAP_END, 16'hAAAA);
        write_reg(CFG_UNMAPPED_TOP, 16'h5555);
        i_cfg_valid <= 1'b0;
        send_run(2, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_output_backpressure();
        clear_plan();
        tap_plan[0] = TAP_W'(1);
        tap_plan[1] = TAP_W'(3);
        tap_plan[2] = TAP_W'(-2);
        tap_plan[3] = TAP_W'(6);
        tap_plan[4] = TAP_W'(2);
        tap_plan[5] = TAP_W'(1);
        tap_plan[6] = TAP_W'(1);
        load_taps(TAP_W'(7));
        tx_calm = 1'b1;
        rx_hold_cycles = HOLD_CYCLES;
        send_run(12, 1'b0);
        // sender waits for every word mid-sequence, then carries on
        wait_for_drain();
        send_run(6, 1'b1);
        tx_calm = 1'b0;
        wait_for_drain();
    endtask

    task automatic randomise_taps();
        logic [TAP_W-1:0] count_word;
        int unsigned len;
        int unsigned mode;
        int k;
        int total;
        count_word = TAP_W'($urandom());
        len  = (count_word[CNT_W-1:0] == 0) ? 1 : count_word[CNT_W-1:0];
        mode = $urandom_range(9);
        for (k = 0; k < MAX_TAPS; k++) begin
            if (mode < 6 || mode == 9)
                tap_plan[k] = TAP_W'($urandom_range(12) - 3);
            else
                tap_plan[k] = TAP_W'($urandom());
        end
        if (mode == 9) begin
            total = 0;
            for (k = 0; k < len - 1; k++)
                total += $signed(tap_plan[k]);
            tap_plan[len - 1] = TAP_W'(-total);
        end
        if ($urandom_range(3) == 0)
            write_reg(CFG_IDX_W'(CFG_TAP_END + $urandom_range(7)), TAP_W'($urandom()));
        load_taps(count_word);
    endtask

    task automatic test_random_phases();
        int p;
        int remaining;
        int n;
        bit closed;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            wait_for_drain();
            randomise_taps();
            tx_calm = (p == 3);
            rx_calm = (p == 3);
            remaining = PHASE_ITEMS;
            while (remaining > 0) begin
                n = ($urandom_range(4) == 0) ? $urandom_range(16, 8) : $urandom_range(7, 1);
                if (n > remaining)
                    n = remaining;
                // a phase may stop mid-sequence so the next settings apply part way
                closed = (n < remaining) || ($urandom_range(9) >= 3);
                send_run(n, closed);
                remaining -= n;
            end
            tx_calm = 1'b0;
            rx_calm = 1'b0;
        end
        wait_for_drain();
    endtask

    initial begin
        reset_filter_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_saturation();
        test_zero_weight_sum();
        test_short_full_window();
        test_zero_tap_count();
        test_mid_sequence_change();
        test_unmapped_index();
        test_output_backpressure();
        test_random_phases();
        $display("sent %0d samples, checked %0d smoothed words, %0d register writes",
                 samples_sent, results_checked, cfg_writes);
        $display("tap counts 0 to 7, zero weight sums, saturation, short and open runs, stalls");
        if (mismatch_count == 0 && pending_words.size() == 0) begin
            $display("normalized_fir_smoother regression: pass");
        end else begin
            $display("normalized_fir_smoother regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("normalized_fir_smoother regression: fail");
        $finish;
    end

endmodule
